// File: rtl/core/tlpq_pkg.sv
`timescale 1ns / 1ps

package tlpq_pkg;

	localparam int LEVELS_DEF = 3;
	localparam int LEVEL_DEPTH_DEF = 16;

	// action codes
	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_DEQ  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;
	localparam logic [1:0] ACT_NOP  = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BADPRIO = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_EMPTY   = 2'd3;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 200;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic wait_calc;
		logic commit;
	} cmd_t;

endpackage

// File: rtl/core/three_level_priority_queue.sv
`timescale 1ns / 1ps
// Each item passes through accept, lookup/store access, wait calc and commit in that order;
// commit waits while the result register holds a result that is not taken. The controller
// holds one item at a time, the store read is registered, and the result is registered at commit.
// The result register lets the next item be accepted while a result waits to be taken.
// Reset (arst_n low, asynchronous): levels empty, counters zero; entry store is not cleared.
module three_level_priority_queue #(
	parameter int LEVELS      = tlpq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// priority_req[2:0], entry_tag[18:3], arrival_time[50:19], now_time[82:51], zero pad
	input  logic [tlpq_pkg::IN_DATA_W-1:0]    s_tdata,
	// action[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_tag[15:0], out_priority[17:16], out_arrival[49:18], out_wait[81:50],
	// level_served[113:82], level_wait_sum[161:114], total_served[193:162],
	// queue_empty[194], zero pad
	output logic [tlpq_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status[1:0]
	output logic [1:0]                        m_tuser
);
	import tlpq_pkg::*;

	cmd_t        cmd;
	logic [15:0] out_tag;
	logic [1:0]  out_priority;
	logic [31:0] out_arrival;
	logic [31:0] out_wait;
	logic [31:0] level_served;
	logic [47:0] level_wait_sum;
	logic [31:0] total_served;
	logic        queue_empty;

	tlpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tlpq_datapath #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.action         (s_tuser),
		.priority_req   (s_tdata[2:0]),
		.entry_tag      (s_tdata[18:3]),
		.arrival_time   (s_tdata[50:19]),
		.now_time       (s_tdata[82:51]),
		.status         (m_tuser),
		.out_tag        (out_tag),
		.out_priority   (out_priority),
		.out_arrival    (out_arrival),
		.out_wait       (out_wait),
		.level_served   (level_served),
		.level_wait_sum (level_wait_sum),
		.total_served   (total_served),
		.queue_empty    (queue_empty)
	);

	assign m_tdata = {5'd0, queue_empty, total_served, level_wait_sum, level_served,
		out_wait, out_arrival, out_priority, out_tag};

endmodule

// File: rtl/core/tlpq_ctrl.sv
`timescale 1ns / 1ps

module tlpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output tlpq_pkg::cmd_t  cmd
);
	import tlpq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_WAIT,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.capture   = (state_q == S_IDLE) && s_tvalid;
		cmd.lookup    = (state_q == S_LOOK);
		cmd.wait_calc = (state_q == S_WAIT);
		cmd.commit    = (state_q == S_COMMIT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_LOOK;
				end
				S_LOOK:   state_q <= S_WAIT;
				S_WAIT:   state_q <= S_COMMIT;
				S_COMMIT: begin
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// result register must be free when a new result lands
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid_q || m_tready))
		else $error("commit into occupied result register");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while busy");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

endmodule

// File: rtl/core/tlpq_datapath.sv
`timescale 1ns / 1ps

module tlpq_datapath #(
	parameter int LEVELS      = tlpq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tlpq_pkg::cmd_t  cmd,
	input  logic [1:0]      action,
	input  logic [2:0]      priority_req,
	input  logic [15:0]     entry_tag,
	input  logic [31:0]     arrival_time,
	input  logic [31:0]     now_time,
	output logic [1:0]      status,
	output logic [15:0]     out_tag,
	output logic [1:0]      out_priority,
	output logic [31:0]     out_arrival,
	output logic [31:0]     out_wait,
	output logic [31:0]     level_served,
	output logic [47:0]     level_wait_sum,
	output logic [31:0]     total_served,
	output logic            queue_empty
);
	import tlpq_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CW = $clog2(LEVEL_DEPTH + 1);
	localparam int MD = LEVELS * LEVEL_DEPTH;
	localparam int AW = $clog2(MD);
	localparam logic [AW-1:0] DEPTH_A  = AW'(LEVEL_DEPTH);
	localparam logic [PW:0]   DEPTH_P  = (PW + 1)'(LEVEL_DEPTH);
	localparam logic [PW-1:0] HEAD_MAX = PW'(LEVEL_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(LEVEL_DEPTH);

	// captured item
	logic [1:0]  act_q;
	logic [2:0]  prio_q;
	logic [15:0] tag_q;
	logic [31:0] arr_q;
	logic [31:0] now_q;

	// per-level state
	logic [PW-1:0] head_q   [LEVELS];
	logic [CW-1:0] cnt_q    [LEVELS];
	logic [31:0]   served_q [LEVELS];
	logic [47:0]   wsum_q   [LEVELS];
	logic [31:0]   total_q;

	// entry store: tag in [47:32], arrival in [31:0]
	logic [47:0] mem [MD];
	logic [47:0] rdata_q;

	// lookup results
	logic [LW-1:0] lv_q;
	logic [1:0]    status_q;
	logic          do_enq_q;
	logic          do_deq_q;
	logic          do_rd_q;
	logic          has_lv_q;
	logic [31:0]   wait_q;

	// lookup logic
	logic [LW-1:0] busy_lv;
	logic          any_busy;
	logic          prio_ok;
	logic [LW-1:0] enq_lv;
	logic [LW-1:0] lv_d;
	logic [PW-1:0] head_d;
	logic [CW-1:0] cnt_d;
	logic [PW:0]   tail_sum;
	logic [PW-1:0] slot_d;
	logic [AW-1:0] addr_d;
	logic [1:0]    status_d;
	logic          enq_ok_d;

	always_comb begin
		busy_lv  = '0;
		any_busy = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				busy_lv  = LW'(i);
				any_busy = 1'b1;
			end
		end
		prio_ok = (prio_q != 3'd0) && ({1'b0, prio_q} <= 4'(LEVELS));
		enq_lv  = LW'(prio_q - 3'd1);
		lv_d    = (act_q == ACT_ENQ) ? enq_lv : busy_lv;
		head_d  = '0;
		cnt_d   = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (lv_d == LW'(i)) begin
				head_d = head_q[i];
				cnt_d  = cnt_q[i];
			end
		end
		tail_sum = {1'b0, head_d} + (PW + 1)'(cnt_d);
		slot_d   = (tail_sum >= DEPTH_P) ? PW'(tail_sum - DEPTH_P) : PW'(tail_sum);
		case (act_q)
			ACT_ENQ: begin
				if (!prio_ok)              status_d = STAT_BADPRIO;
				else if (cnt_d == DEPTH_C) status_d = STAT_FULL;
				else                       status_d = STAT_OK;
			end
			ACT_DEQ, ACT_PEEK: status_d = any_busy ? STAT_OK : STAT_EMPTY;
			default:           status_d = STAT_OK;
		endcase
		enq_ok_d = (act_q == ACT_ENQ) && (status_d == STAT_OK);
		addr_d   = AW'(lv_d * DEPTH_A) + AW'(enq_ok_d ? slot_d : head_d);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			prio_q <= priority_req;
			tag_q  <= entry_tag;
			arr_q  <= arrival_time;
			now_q  <= now_time;
		end
		if (cmd.lookup) begin
			lv_q     <= lv_d;
			status_q <= status_d;
			do_enq_q <= enq_ok_d;
			do_deq_q <= (act_q == ACT_DEQ) && any_busy;
			do_rd_q  <= ((act_q == ACT_DEQ) || (act_q == ACT_PEEK)) && any_busy;
			has_lv_q <= (status_d == STAT_OK) && (act_q != ACT_NOP);
			if (enq_ok_d) begin
				mem[addr_d] <= {tag_q, arr_q};
			end else begin
				rdata_q <= mem[addr_d];
			end
		end
		if (cmd.wait_calc) begin
			wait_q <= (now_q >= rdata_q[31:0]) ? now_q - rdata_q[31:0] : 32'd0;
		end
	end

	// commit logic
	logic [PW-1:0] head_sel;
	logic [CW-1:0] cnt_sel;
	logic [31:0]   served_sel;
	logic [47:0]   wsum_sel;
	logic [48:0]   wsum_add;
	logic [47:0]   wsum_new;
	logic [PW-1:0] head_new;
	logic [LW:0]   prio_p1;
	logic          empty_d;
	logic [CW-1:0] cnt_nxt;

	always_comb begin
		head_sel   = '0;
		cnt_sel    = '0;
		served_sel = '0;
		wsum_sel   = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (lv_q == LW'(i)) begin
				head_sel   = head_q[i];
				cnt_sel    = cnt_q[i];
				served_sel = served_q[i];
				wsum_sel   = wsum_q[i];
			end
		end
		wsum_add = {1'b0, wsum_sel} + {17'd0, wait_q};
		wsum_new = wsum_add[48] ? '1 : wsum_add[47:0];
		head_new = (head_sel == HEAD_MAX) ? '0 : head_sel + PW'(1);
		prio_p1  = {1'b0, lv_q} + (LW + 1)'(1);
		empty_d  = 1'b1;
		for (int i = 0; i < LEVELS; i++) begin
			cnt_nxt = cnt_q[i];
			if (lv_q == LW'(i) && do_enq_q) cnt_nxt = cnt_q[i] + CW'(1);
			if (lv_q == LW'(i) && do_deq_q) cnt_nxt = cnt_q[i] - CW'(1);
			if (cnt_nxt != '0) empty_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]   <= '0;
				cnt_q[i]    <= '0;
				served_q[i] <= '0;
				wsum_q[i]   <= '0;
			end
			total_q <= '0;
		end else if (cmd.commit) begin
			for (int i = 0; i < LEVELS; i++) begin
				if (lv_q == LW'(i)) begin
					if (do_enq_q) cnt_q[i] <= cnt_sel + CW'(1);
					if (do_deq_q) begin
						cnt_q[i]    <= cnt_sel - CW'(1);
						head_q[i]   <= head_new;
						served_q[i] <= served_sel + 32'd1;
						wsum_q[i]   <= wsum_new;
					end
				end
			end
			if (do_deq_q) total_q <= total_q + 32'd1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status         <= status_q;
			out_tag        <= do_rd_q ? rdata_q[47:32] : 16'd0;
			out_priority   <= has_lv_q ? prio_p1[1:0] : 2'd0;
			out_arrival    <= do_rd_q ? rdata_q[31:0] : 32'd0;
			out_wait       <= do_deq_q ? wait_q : 32'd0;
			level_served   <= !has_lv_q ? 32'd0 : (do_deq_q ? served_sel + 32'd1 : served_sel);
			level_wait_sum <= !has_lv_q ? 48'd0 : (do_deq_q ? wsum_new : wsum_sel);
			total_served   <= do_deq_q ? total_q + 32'd1 : total_q;
			queue_empty    <= empty_d;
		end
	end

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_deq_q) |-> (cnt_sel != '0))
		else $error("dequeue from empty level");

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_enq_q) |-> (cnt_sel < DEPTH_C))
		else $error("enqueue into full level");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_deq_q) |=> (total_q == $past(total_q) + 32'd1))
		else $error("total served not advanced on dequeue");

endmodule
